// ===== src/spr_pkg.sv =====
// Shared types and constants for the sump pump run controller.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package spr_pkg;

    // Field widths of one input item, one result item and the config port.
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned LEVEL_W     = 16;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned MINUTES_W   = 11;
    localparam int unsigned SECONDS_W   = 12;

    // Scale factors from the configured units to milliseconds.
    localparam int unsigned MS_PER_MINUTE = 60000;
    localparam int unsigned MS_PER_SECOND = 1000;

    // 2047 minutes is 122,820,000 ms (27 bits); 4095 s is 4,095,000 ms (22 bits).
    localparam int unsigned MAX_MS_W = 27;
    localparam int unsigned LOW_MS_W = 22;

    // Configuration reset values.
    localparam int unsigned RESET_MAX_MINUTES = 60;
    localparam int unsigned RESET_LOW_SECONDS = 30;
    localparam int unsigned RESET_STOP_LEVEL  = 200;
    localparam int unsigned RESET_START_LEVEL = 800;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_MAN_ON  = 2'd1,
        KIND_MAN_OFF = 2'd2,
        KIND_AUTO    = 2'd3
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_AUTO    = 2'd0,
        MODE_MAN_ON  = 2'd1,
        MODE_MAN_OFF = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RUNTIME = 2'd0,
        CFG_LOW_DELAY   = 2'd1,
        CFG_STOP_LEVEL  = 2'd2,
        CFG_START_LEVEL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TIME_W-1:0]  now_ms;
        logic               level_valid;
        logic [LEVEL_W-1:0] level_mm;
        logic               flood_confirmed;
    } in_item_t;

    typedef struct packed {
        logic               pump_running;
        logic [MODE_W-1:0]  mode;
        logic [TIME_W-1:0]  runtime_ms;
        logic               max_runtime_hit;
        logic               dry_run_hit;
    } out_item_t;

    // Limits as the evaluation logic uses them, already scaled to milliseconds.
    typedef struct packed {
        logic [MAX_MS_W-1:0] max_ms;
        logic [LOW_MS_W-1:0] low_ms;
        logic [LEVEL_W-1:0]  stop_level;
        logic [LEVEL_W-1:0]  start_level;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/spr_channels.sv =====
// Handshake channel interfaces of the sump pump run controller: input items,
// result items and configuration writes. Depends on spr_pkg for widths.
`default_nettype none

interface spr_in_if;
    logic                        valid;
    logic                        ready;
    logic [spr_pkg::KIND_W-1:0]  kind;
    logic [spr_pkg::TIME_W-1:0]  now_ms;
    logic                        level_valid;
    logic [spr_pkg::LEVEL_W-1:0] level_mm;
    logic                        flood_confirmed;

    modport source (output valid, kind, now_ms, level_valid, level_mm, flood_confirmed,
                    input ready);
    modport sink   (input valid, kind, now_ms, level_valid, level_mm, flood_confirmed,
                    output ready);
endinterface

interface spr_out_if;
    logic                       valid;
    logic                       ready;
    logic                       pump_running;
    logic [spr_pkg::MODE_W-1:0] mode;
    logic [spr_pkg::TIME_W-1:0] runtime_ms;
    logic                       max_runtime_hit;
    logic                       dry_run_hit;

    modport source (output valid, pump_running, mode, runtime_ms, max_runtime_hit,
                    dry_run_hit, input ready);
    modport sink   (input valid, pump_running, mode, runtime_ms, max_runtime_hit,
                    dry_run_hit, output ready);
endinterface

interface spr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spr_pkg::CFG_IDX_W-1:0]  index;
    logic [spr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/spr_cfg_regs.sv =====
// Configuration register file of the sump pump run controller.
// Depends on spr_pkg and the spr_cfg_if channel interface.
`default_nettype none

module spr_cfg_regs
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    spr_cfg_if.sink       cfg_ch,
    output spr_pkg::cfg_t cfg
);

    spr_pkg::cfg_t cfg_reg;

    // Time limits are scaled to milliseconds once, when written.
    logic [spr_pkg::MAX_MS_W-1:0] max_ms_wr;
    logic [spr_pkg::LOW_MS_W-1:0] low_ms_wr;

    assign max_ms_wr = spr_pkg::MAX_MS_W'(cfg_ch.data[spr_pkg::MINUTES_W-1:0])
                     * spr_pkg::MAX_MS_W'(spr_pkg::MS_PER_MINUTE);
    assign low_ms_wr = spr_pkg::LOW_MS_W'(cfg_ch.data[spr_pkg::SECONDS_W-1:0])
                     * spr_pkg::LOW_MS_W'(spr_pkg::MS_PER_SECOND);

    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_ms      <= spr_pkg::MAX_MS_W'(spr_pkg::RESET_MAX_MINUTES
                                                      * spr_pkg::MS_PER_MINUTE);
            cfg_reg.low_ms      <= spr_pkg::LOW_MS_W'(spr_pkg::RESET_LOW_SECONDS
                                                      * spr_pkg::MS_PER_SECOND);
            cfg_reg.stop_level  <= spr_pkg::LEVEL_W'(spr_pkg::RESET_STOP_LEVEL);
            cfg_reg.start_level <= spr_pkg::LEVEL_W'(spr_pkg::RESET_START_LEVEL);
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (spr_pkg::cfg_idx_t'(cfg_ch.index))
                spr_pkg::CFG_MAX_RUNTIME: cfg_reg.max_ms      <= max_ms_wr;
                spr_pkg::CFG_LOW_DELAY:   cfg_reg.low_ms      <= low_ms_wr;
                spr_pkg::CFG_STOP_LEVEL:  cfg_reg.stop_level  <= cfg_ch.data;
                spr_pkg::CFG_START_LEVEL: cfg_reg.start_level <= cfg_ch.data;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/spr_core.sv =====
// Run-control state and per-item evaluation of the sump pump run controller.
// Depends on spr_pkg; instantiated by the top level.
`default_nettype none

module spr_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire spr_pkg::in_item_t item,
    input  wire spr_pkg::cfg_t     cfg,
    output spr_pkg::out_item_t     result
);

    logic                       running_reg,   running_next;
    spr_pkg::mode_t             mode_reg,      mode_next;
    logic [spr_pkg::TIME_W-1:0] start_reg,     start_next;
    logic                       tracking_reg,  tracking_next;
    logic [spr_pkg::TIME_W-1:0] low_since_reg, low_since_next;
    logic                       max_flag_reg,  max_flag_next;
    logic                       dry_flag_reg,  dry_flag_next;

    logic                       level_low;
    logic                       level_high;
    logic [spr_pkg::TIME_W-1:0] run_elapsed;
    logic [spr_pkg::TIME_W-1:0] low_elapsed;
    logic                       max_reached;
    logic                       low_reached;
    logic [spr_pkg::TIME_W-1:0] runtime_now;

    assign level_low   = item.level_valid && (item.level_mm <= cfg.stop_level);
    assign level_high  = item.level_valid && (item.level_mm >= cfg.start_level);
    assign run_elapsed = item.now_ms - start_reg;
    assign low_elapsed = item.now_ms - low_since_reg;
    assign max_reached = run_elapsed >= spr_pkg::TIME_W'(cfg.max_ms);
    assign low_reached = low_elapsed >= spr_pkg::TIME_W'(cfg.low_ms);

    always_comb
    begin
        running_next   = running_reg;
        mode_next      = mode_reg;
        start_next     = start_reg;
        tracking_next  = tracking_reg;
        low_since_next = low_since_reg;
        max_flag_next  = max_flag_reg;
        dry_flag_next  = dry_flag_reg;

        unique case (spr_pkg::kind_t'(item.kind))
            spr_pkg::KIND_TICK:
            begin
                // Maximum-runtime stop comes first.
                if (running_next && max_reached)
                begin
                    running_next  = 1'b0;
                    tracking_next = 1'b0;
                    max_flag_next = 1'b1;
                end
                // Dry-run stop: the low level must persist from an earlier tick.
                if (running_next)
                begin
                    if (level_low)
                    begin
                        if (!tracking_reg)
                        begin
                            tracking_next  = 1'b1;
                            low_since_next = item.now_ms;
                        end
                        else if (low_reached)
                        begin
                            running_next  = 1'b0;
                            tracking_next = 1'b0;
                            dry_flag_next = 1'b1;
                        end
                    end
                    else
                    begin
                        tracking_next = 1'b0;
                    end
                end
                // Auto start may follow a stop on the same tick.
                if (mode_reg == spr_pkg::MODE_AUTO && !running_next
                    && item.flood_confirmed && level_high)
                begin
                    running_next  = 1'b1;
                    start_next    = item.now_ms;
                    tracking_next = 1'b0;
                    max_flag_next = 1'b0;
                    dry_flag_next = 1'b0;
                end
            end
            spr_pkg::KIND_MAN_ON:
            begin
                mode_next = spr_pkg::MODE_MAN_ON;
                if (!running_reg)
                begin
                    running_next  = 1'b1;
                    start_next    = item.now_ms;
                    tracking_next = 1'b0;
                    max_flag_next = 1'b0;
                    dry_flag_next = 1'b0;
                end
            end
            spr_pkg::KIND_MAN_OFF:
            begin
                mode_next     = spr_pkg::MODE_MAN_OFF;
                running_next  = 1'b0;
                tracking_next = tracking_reg && !running_reg;
            end
            spr_pkg::KIND_AUTO:
            begin
                mode_next = spr_pkg::MODE_AUTO;
            end
        endcase
    end

    assign runtime_now = item.now_ms - start_next;

    always_comb
    begin
        result.pump_running    = running_next;
        result.mode            = mode_next;
        result.runtime_ms      = running_next ? runtime_now : '0;
        result.max_runtime_hit = max_flag_next;
        result.dry_run_hit     = dry_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            mode_reg      <= spr_pkg::MODE_AUTO;
            start_reg     <= '0;
            tracking_reg  <= 1'b0;
            low_since_reg <= '0;
            max_flag_reg  <= 1'b0;
            dry_flag_reg  <= 1'b0;
        end
        else if (fire)
        begin
            running_reg   <= running_next;
            mode_reg      <= mode_next;
            start_reg     <= start_next;
            tracking_reg  <= tracking_next;
            low_since_reg <= low_since_next;
            max_flag_reg  <= max_flag_next;
            dry_flag_reg  <= dry_flag_next;
        end
    end

    // A stop records at most one reason, and every start clears both.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(max_flag_reg && dry_flag_reg))
        else $error("spr_core: both stop reasons flagged");

    // Manual-on always leaves the pump running in manual-on mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.kind == spr_pkg::KIND_MAN_ON
        |=> running_reg && mode_reg == spr_pkg::MODE_MAN_ON)
        else $error("spr_core: manual-on did not run the pump");

    // Without a transaction the run state does not move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(running_reg) && $stable(start_reg) && $stable(mode_reg))
        else $error("spr_core: state changed without a transaction");

    // Low-level tracking only exists while the pump runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        tracking_reg |-> running_reg)
        else $error("spr_core: low tracking while stopped");

endmodule

`default_nettype wire

// ===== src/sump_pump_run_controller.sv =====
// Sump pump run controller, top level. Depends on spr_pkg, the spr_channels
// interfaces, spr_cfg_regs and spr_core.
//
// Each input transaction is an evaluation tick, manual-on, manual-off or auto
// command, carrying the millisecond time, the level reading and the flood flag.
// The block returns exactly one result transaction per input transaction, in
// order: the pump drive, the mode, the current run time and the two sticky stop
// reasons, all as they stand after that item. An item is captured into an input
// register, evaluated against the run state by a single pass of compare and
// subtract logic, and the result is captured into an output register in the
// same edge that updates the run state. The block sustains one transaction per
// clock while the result side takes every result; an accepted item passes the
// input register and then the output register before its result is shown. The
// output register decouples the two sides, so a new item is taken while a
// finished result waits; a stalled output also holds the input once it is full.
// Configuration writes are accepted in every cycle and take effect at once;
// they are meant to be issued while no item is in flight. Time differences
// wrap modulo 2^32, so the run and dry-run timers survive a clock rollover.
`default_nettype none

module sump_pump_run_controller
(
    input  wire logic clk,
    input  wire logic rst_n,
    spr_in_if.sink    in_ch,
    spr_out_if.source out_ch,
    spr_cfg_if.sink   cfg_ch
);

    logic               in_valid_reg;
    spr_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    spr_pkg::out_item_t out_item_reg;

    spr_pkg::cfg_t      cfg;
    spr_pkg::out_item_t result;
    logic               advance;

    // The held item moves on when the output register is free or being emptied.
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || !out_valid_reg || out_ch.ready;

    spr_cfg_regs u_cfg_regs
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    spr_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.kind            <= in_ch.kind;
            in_item_reg.now_ms          <= in_ch.now_ms;
            in_item_reg.level_valid     <= in_ch.level_valid;
            in_item_reg.level_mm        <= in_ch.level_mm;
            in_item_reg.flood_confirmed <= in_ch.flood_confirmed;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.pump_running    = out_item_reg.pump_running;
    assign out_ch.mode            = out_item_reg.mode;
    assign out_ch.runtime_ms      = out_item_reg.runtime_ms;
    assign out_ch.max_runtime_hit = out_item_reg.max_runtime_hit;
    assign out_ch.dry_run_hit     = out_item_reg.dry_run_hit;

    // A stopped pump never reports run time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.pump_running |-> out_ch.runtime_ms == '0)
        else $error("sump_pump_run_controller: run time reported while stopped");

    // A held item with a full, stalled output blocks further input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ch.ready |-> !in_ch.ready && !advance)
        else $error("sump_pump_run_controller: input taken while pipeline full");

    // Every evaluated item produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("sump_pump_run_controller: result lost");

endmodule

`default_nettype wire

// ===== verif/spr_run_checker.sv =====
// Result checker for the sump pump run controller: tracks the pump state from the
// accepted input and configuration transactions and compares every result transaction.
// Depends on spr_pkg and the spr_channels interfaces.

module spr_run_checker
(
    input  wire logic clk,
    input  wire logic rst_n,
    spr_in_if         in_mon,
    spr_out_if        out_mon,
    spr_cfg_if        cfg_mon,
    output int        mismatches,
    output int        pending
);
    import spr_pkg::*;

    // Limits held in milliseconds, as the tick evaluation uses them.
    logic [TIME_W-1:0]  max_run_ms;
    logic [TIME_W-1:0]  low_hold_ms;
    logic [LEVEL_W-1:0] stop_mm;
    logic [LEVEL_W-1:0] start_mm;

    logic               pump_on;
    mode_t              run_mode_q;
    logic [TIME_W-1:0]  run_start;
    logic               low_armed;
    logic [TIME_W-1:0]  low_since;
    logic               max_stop_flag;
    logic               dry_stop_flag;

    out_item_t          expected_q[$];
    in_item_t           seen;
    out_item_t          got;
    out_item_t          want;
    int                 miss_total;

    function automatic void begin_run(input logic [TIME_W-1:0] now);
        pump_on       = 1'b1;
        run_start     = now;
        low_armed     = 1'b0;
        max_stop_flag = 1'b0;
        dry_stop_flag = 1'b0;
    endfunction

    function automatic void end_run();
        pump_on   = 1'b0;
        low_armed = 1'b0;
    endfunction

    // Applies one input transaction to the tracked state and returns the
    // result the block must produce for it.
    function automatic out_item_t step_controller(input in_item_t it);
        logic      low_now;
        logic      high_now;
        out_item_t r;
        low_now  = it.level_valid && (it.level_mm <= stop_mm);
        high_now = it.level_valid && (it.level_mm >= start_mm);
        case (kind_t'(it.kind))
            KIND_TICK:
            begin
                if (pump_on && ((it.now_ms - run_start) >= max_run_ms))
                begin
                    end_run();
                    max_stop_flag = 1'b1;
                end
                if (pump_on)
                begin
                    if (!low_now)
                        low_armed = 1'b0;
                    else if (!low_armed)
                    begin
                        low_armed = 1'b1;
                        low_since = it.now_ms;
                    end
                    else if ((it.now_ms - low_since) >= low_hold_ms)
                    begin
                        end_run();
                        dry_stop_flag = 1'b1;
                    end
                end
                if (run_mode_q == MODE_AUTO && !pump_on && it.flood_confirmed && high_now)
                    begin_run(it.now_ms);
            end
            KIND_MAN_ON:
            begin
                run_mode_q = MODE_MAN_ON;
                if (!pump_on)
                    begin_run(it.now_ms);
            end
            KIND_MAN_OFF:
            begin
                run_mode_q = MODE_MAN_OFF;
                if (pump_on)
                    end_run();
            end
            KIND_AUTO:
                run_mode_q = MODE_AUTO;
        endcase
        r.pump_running    = pump_on;
        r.mode            = run_mode_q;
        r.runtime_ms      = pump_on ? (it.now_ms - run_start) : '0;
        r.max_runtime_hit = max_stop_flag;
        r.dry_run_hit     = dry_stop_flag;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_ms    = TIME_W'(RESET_MAX_MINUTES) * MS_PER_MINUTE;
            low_hold_ms   = TIME_W'(RESET_LOW_SECONDS) * MS_PER_SECOND;
            stop_mm       = LEVEL_W'(RESET_STOP_LEVEL);
            start_mm      = LEVEL_W'(RESET_START_LEVEL);
            pump_on       = 1'b0;
            run_mode_q    = MODE_AUTO;
            run_start     = '0;
            low_armed     = 1'b0;
            low_since     = '0;
            max_stop_flag = 1'b0;
            dry_stop_flag = 1'b0;
            expected_q.delete();
            miss_total    = 0;
            mismatches   <= 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_idx_t'(cfg_mon.index))
                    CFG_MAX_RUNTIME:
                        max_run_ms = TIME_W'(cfg_mon.data[MINUTES_W-1:0]) * MS_PER_MINUTE;
                    CFG_LOW_DELAY:
                        low_hold_ms = TIME_W'(cfg_mon.data[SECONDS_W-1:0]) * MS_PER_SECOND;
                    CFG_STOP_LEVEL:
                        stop_mm = cfg_mon.data[LEVEL_W-1:0];
                    CFG_START_LEVEL:
                        start_mm = cfg_mon.data[LEVEL_W-1:0];
                endcase
            end

            // Results are compared before this edge's input is predicted, so a
            // result can never be matched against the transaction it arrives with.
            if (out_mon.valid && out_mon.ready)
            begin
                got.pump_running    = out_mon.pump_running;
                got.mode            = out_mon.mode;
                got.runtime_ms      = out_mon.runtime_ms;
                got.max_runtime_hit = out_mon.max_runtime_hit;
                got.dry_run_hit     = out_mon.dry_run_hit;
                if (expected_q.size() == 0)
                begin
                    if (miss_total < 10)
                        $display("%0t: result with no transaction pending: run=%0b mode=%0d",
                                 $realtime, got.pump_running, got.mode);
                    miss_total++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.pump_running !== want.pump_running || got.mode !== want.mode ||
                        got.runtime_ms !== want.runtime_ms ||
                        got.max_runtime_hit !== want.max_runtime_hit ||
                        got.dry_run_hit !== want.dry_run_hit)
                    begin
                        if (miss_total < 10)
                            $display({"%0t: result mismatch: expected run=%0b mode=%0d ",
                                      "runtime=%0d max=%0b dry=%0b, got run=%0b mode=%0d ",
                                      "runtime=%0d max=%0b dry=%0b"},
                                     $realtime, want.pump_running, want.mode,
                                     want.runtime_ms, want.max_runtime_hit,
                                     want.dry_run_hit, got.pump_running, got.mode,
                                     got.runtime_ms, got.max_runtime_hit, got.dry_run_hit);
                        miss_total++;
                    end
                end
            end

            if (in_mon.valid && in_mon.ready)
            begin
                seen.kind            = in_mon.kind;
                seen.now_ms          = in_mon.now_ms;
                seen.level_valid     = in_mon.level_valid;
                seen.level_mm        = in_mon.level_mm;
                seen.flood_confirmed = in_mon.flood_confirmed;
                expected_q.push_back(step_controller(seen));
            end

            mismatches <= miss_total;
            pending    <= expected_q.size();
        end
    end

endmodule

// ===== verif/sump_pump_run_controller_test.sv =====
// Testbench top for the sump pump run controller: drives input and configuration
// transactions, paces the result side, and reports the verdict of spr_run_checker.
// Depends on spr_pkg, the spr_channels interfaces, the block and spr_run_checker.

module sump_pump_run_controller_test;
    import spr_pkg::*;

    // The run is split into six phases. Each phase after the first loads a new
    // set of limits while the block is idle, and the phases rotate through the
    // three pacing modes: sender light and receiver heavy, the reverse, and none.
    localparam int ITEMS_PER_PHASE = 288;
    localparam int PHASES          = 6;
    localparam int HOLD_CYCLES     = 64;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    spr_in_if  in_ch ();
    spr_out_if out_ch ();
    spr_cfg_if cfg_ch ();

    int mismatches;
    int pending;

    // Pacing knobs, in percent of cycles spent idle on each side.
    int   send_idle_pct;
    int   recv_idle_pct;
    // Asks the result side for one long stall while the sender keeps offering.
    logic hold_req;

    // The stimulus keeps its own copy of the limits so that it can aim levels
    // and time steps at the thresholds and delays currently in force.
    logic [TIME_W-1:0]    clock_ms;
    logic [MINUTES_W-1:0] cfg_minutes;
    logic [SECONDS_W-1:0] cfg_seconds;
    logic [LEVEL_W-1:0]   cfg_stop;
    logic [LEVEL_W-1:0]   cfg_start;

    sump_pump_run_controller dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    spr_run_checker run_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .cfg_mon    (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one input transaction and returns once it has been accepted. The
    // handshake is sampled right after the edge, before any register of that
    // edge has updated, so it reflects what the block saw at the edge. Valid is
    // only lowered when a gap is inserted, so back-to-back transactions keep it
    // high without a second assignment in the same step.
    task automatic send_item(input kind_t k, input logic [TIME_W-1:0] t, input logic lv,
                             input logic [LEVEL_W-1:0] lvl, input logic fl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.kind            <= k;
        in_ch.now_ms          <= t;
        in_ch.level_valid     <= lv;
        in_ch.level_mm        <= lvl;
        in_ch.flood_confirmed <= fl;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    // Waits until every result has come back, then lets the two-stage pipeline
    // settle before anything else happens. The first edge lets the checker's
    // count take in the last accepted input.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four limit registers in one burst. Valid stays high across the
    // burst and is dropped once after the last write.
    task automatic load_limits(input logic [MINUTES_W-1:0] minutes,
                               input logic [SECONDS_W-1:0] seconds,
                               input logic [LEVEL_W-1:0] stop_mm,
                               input logic [LEVEL_W-1:0] start_mm);
        cfg_idx_t              order [4];
        logic [CFG_DATA_W-1:0] value [4];
        order[0] = CFG_MAX_RUNTIME;
        order[1] = CFG_LOW_DELAY;
        order[2] = CFG_STOP_LEVEL;
        order[3] = CFG_START_LEVEL;
        value[0] = CFG_DATA_W'(minutes);
        value[1] = CFG_DATA_W'(seconds);
        value[2] = CFG_DATA_W'(stop_mm);
        value[3] = CFG_DATA_W'(start_mm);
        cfg_ch.valid <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.index <= order[i];
            cfg_ch.data  <= value[i];
            do
                @(posedge clk);
            while (cfg_ch.ready !== 1'b1);
        end
        cfg_ch.valid <= 1'b0;
        cfg_minutes = minutes;
        cfg_seconds = seconds;
        cfg_stop    = stop_mm;
        cfg_start   = start_mm;
    endtask

    // Moves the millisecond clock forward. Many steps are short, more are
    // scaled to the dry-run delay or the run limit in force so that both stops
    // fire regularly, and a few jump anywhere, which also crosses the rollover.
    function automatic void step_clock();
        logic [TIME_W-1:0] max_ms;
        logic [TIME_W-1:0] low_ms;
        max_ms = TIME_W'(cfg_minutes) * MS_PER_MINUTE;
        low_ms = TIME_W'(cfg_seconds) * MS_PER_SECOND;
        case ($urandom_range(19))
            0:                   clock_ms = $urandom();
            1:                   clock_ms = clock_ms;
            2, 3, 4, 5, 6, 7, 8: clock_ms += $urandom_range(1500);
            9, 10, 11, 12, 13:   clock_ms += $urandom_range(low_ms + 2000);
            14, 15, 16:          clock_ms += $urandom_range(max_ms / 4 + 1000);
            default:             clock_ms += $urandom_range(max_ms + 60000);
        endcase
    endfunction

    // A level reading aimed at the edges of both thresholds, or anywhere.
    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return '0;
            1:       return cfg_stop;
            2:       return LEVEL_W'(cfg_stop + 1'b1);
            3:       return LEVEL_W'(cfg_start - 1'b1);
            4:       return cfg_start;
            5:       return '1;
            default: return LEVEL_W'($urandom_range(65535));
        endcase
    endfunction

    // One fill-and-drain cycle of the sump: a start, then a run of ticks in
    // which the water mostly falls to the stop level. A tenth of the starts are
    // spoiled and some ticks carry a manual stop or a rising level instead.
    task automatic pump_cycle(inout int count);
        int ticks;
        int lead;
        lead = $urandom_range(19);
        if (lead < 12)
        begin
            step_clock();
            send_item(KIND_AUTO, clock_ms, 1'b1, pick_level(), 1'($urandom_range(1)));
            count++;
        end
        step_clock();
        if (lead >= 17)
            send_item(KIND_MAN_ON, clock_ms, 1'($urandom_range(1)), pick_level(),
                      1'($urandom_range(1)));
        else if ($urandom_range(9) == 0)
            send_item(KIND_TICK, clock_ms, 1'($urandom_range(1)), pick_level(),
                      1'($urandom_range(1)));
        else
            send_item(KIND_TICK, clock_ms, 1'b1,
                      LEVEL_W'($urandom_range(65535, cfg_start)), 1'b1);
        count++;
        ticks = $urandom_range(12, 3);
        repeat (ticks)
        begin
            step_clock();
            case ($urandom_range(7))
                0, 1, 2, 3:
                    send_item(KIND_TICK, clock_ms, 1'($urandom_range(9) != 0),
                              LEVEL_W'($urandom_range(cfg_stop, 0)), 1'($urandom_range(1)));
                4:
                    send_item(KIND_MAN_OFF, clock_ms, 1'($urandom_range(1)), pick_level(),
                              1'($urandom_range(1)));
                5:
                    send_item(KIND_TICK, clock_ms, 1'b1,
                              LEVEL_W'($urandom_range(65535, cfg_start)), 1'b1);
                default:
                    send_item(KIND_TICK, clock_ms, 1'($urandom_range(9) != 0), pick_level(),
                              1'($urandom_range(1)));
            endcase
            count++;
        end
    endtask

    // Result side. A long stall is granted once on request; otherwise ready
    // follows the idle percentage of the current phase.
    initial
    begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        int                sent;
        bit                hold_asked;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;

        in_ch.valid           <= 1'b0;
        in_ch.kind            <= KIND_TICK;
        in_ch.now_ms          <= '0;
        in_ch.level_valid     <= 1'b0;
        in_ch.level_mm        <= '0;
        in_ch.flood_confirmed <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= CFG_MAX_RUNTIME;
        cfg_ch.data           <= '0;
        hold_req              <= 1'b0;
        recv_idle_pct         <= 0;
        send_idle_pct = 0;
        hold_asked    = 1'b0;
        cfg_minutes   = MINUTES_W'(RESET_MAX_MINUTES);
        cfg_seconds   = SECONDS_W'(RESET_LOW_SECONDS);
        cfg_stop      = LEVEL_W'(RESET_STOP_LEVEL);
        cfg_start     = LEVEL_W'(RESET_START_LEVEL);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                case (phase)
                    1: load_limits('0, '0, '0, '0);
                    2: load_limits(11'd1, 12'd1, 16'd200, 16'd800);
                    3: load_limits('1, '1, '1, '1);
                    4: load_limits(11'd1440, 12'd3600, 16'd1000, 16'd1000);
                    default: load_limits(11'd2, 12'd5, 16'd300, 16'd500);
                endcase
            end

            case (phase % 3)
                0:
                begin
                    send_idle_pct = 18;
                    recv_idle_pct <= 62;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_idle_pct <= 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase

            if (phase == 0)
            begin
                // Directed part, run with the limits left by reset: one hour
                // of run time, thirty seconds of dry-run delay, stop at 200 mm
                // and start at 800 mm. The clock starts just below the
                // rollover so the first runs span it.
                t0 = 32'hFFFF_0000;
                // Level exactly at the start threshold but no flood.
                send_item(KIND_TICK, t0, 1'b1, 16'd800, 1'b0);
                // Flood, but one millimeter short of the threshold.
                send_item(KIND_TICK, t0, 1'b1, 16'd799, 1'b1);
                // Flood and a full-scale level, but the reading is invalid.
                send_item(KIND_TICK, t0, 1'b0, 16'hFFFF, 1'b1);
                // Auto start exactly at the threshold.
                send_item(KIND_TICK, t0, 1'b1, 16'd800, 1'b1);
                // Level at the stop threshold arms the dry-run timer.
                t1 = t0 + 1000;
                send_item(KIND_TICK, t1, 1'b1, 16'd200, 1'b1);
                // One millisecond before the delay runs out, then exactly at it.
                send_item(KIND_TICK, t1 + 29999, 1'b1, 16'd0, 1'b0);
                send_item(KIND_TICK, t1 + 30000, 1'b1, 16'd200, 1'b0);
                // Restart at the all-ones time clears the dry-run flag.
                t0 = 32'hFFFF_FFFF;
                send_item(KIND_TICK, t0, 1'b1, 16'hFFFF, 1'b1);
                // Just short of the run limit, with a mid-range level.
                send_item(KIND_TICK, t0 + 3_599_999, 1'b1, 16'd500, 1'b0);
                // The run limit stops the pump and the same tick restarts it.
                t0 = t0 + 3_600_000;
                send_item(KIND_TICK, t0, 1'b1, 16'hFFFF, 1'b1);
                // Run limit again without a restart, so the flag stays set.
                t0 = t0 + 3_600_000;
                send_item(KIND_TICK, t0, 1'b1, 16'd500, 1'b0);
                // Manual start, then manual-on again while already running.
                t0 = t0 + 10;
                send_item(KIND_MAN_ON, t0, 1'b1, 16'd0, 1'b0);
                send_item(KIND_MAN_ON, t0 + 50, 1'b0, 16'hFFFF, 1'b1);
                // A manual run is still cut by the run limit and never restarted.
                send_item(KIND_TICK, t0 + 3_600_000, 1'b1, 16'hFFFF, 1'b1);
                // Manual-off on a stopped pump keeps the sticky flag.
                send_item(KIND_MAN_OFF, t0 + 3_600_100, 1'b1, 16'd0, 1'b0);
                send_item(KIND_TICK, t0 + 3_600_200, 1'b1, 16'hFFFF, 1'b1);
                // Manual start and manual stop of a running pump.
                send_item(KIND_MAN_ON, t0 + 3_600_300, 1'b1, 16'd0, 1'b1);
                send_item(KIND_MAN_OFF, t0 + 3_600_400, 1'b0, 16'd0, 1'b0);
                // Back to auto; only the mode changes.
                t0 = 32'h8000_0000;
                send_item(KIND_AUTO, t0, 1'b1, 16'hFFFF, 1'b1);
                send_item(KIND_TICK, t0 + 1, 1'b1, 16'hFFFF, 1'b1);
                // An invalid zero reading must not count as low water.
                send_item(KIND_TICK, t0 + 10, 1'b0, 16'd0, 1'b1);
                // Auto command while running leaves the pump alone.
                send_item(KIND_AUTO, t0 + 20, 1'b1, 16'd0, 1'b0);
                // Time zero: the run time wraps far past the limit.
                send_item(KIND_TICK, 32'h0000_0000, 1'b1, 16'd0, 1'b0);
                clock_ms = 32'hFFF0_0000;
            end

            // Random part: mostly complete pump cycles, the rest loose noise
            // of every kind with arbitrary fields.
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(99) < 70)
                    pump_cycle(sent);
                else
                begin
                    if ($urandom_range(3) == 0)
                        clock_ms = $urandom();
                    else
                        step_clock();
                    send_item(kind_t'($urandom_range(3)), clock_ms, 1'($urandom_range(1)),
                              ($urandom_range(1) != 0) ? pick_level()
                                                       : LEVEL_W'($urandom_range(65535)),
                              1'($urandom_range(1)));
                    sent++;
                end
                // In the phase without idling, stall the result side for a long
                // stretch once so that both pipeline registers fill and the
                // block has to push back on its input.
                if (phase == 2 && sent >= 120 && !hold_asked)
                begin
                    hold_req <= 1'b1;
                    hold_asked = 1'b1;
                end
            end
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
